[src/crcchk_pkg.sv]
// Shared constants and types for the calibration record CRC check.
// No dependencies; imported by crcchk_crc16 and the top level.
`timescale 1ns / 1ps

package crcchk_pkg;

	localparam int unsigned WORD_W = 16;
	localparam int unsigned CNT_W  = 6;

	localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

	localparam logic [CNT_W-1:0] CNT_MAX      = 6'd63;
	localparam logic [CNT_W-1:0] OFFSET_FIRST = 6'd12;
	localparam logic [CNT_W-1:0] OFFSET_LAST  = 6'd14;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0]  count_t;

	// Result item as held in the output register
	typedef struct packed {
		logic  uncalibrated;
		logic  record_error;
		word_t computed_crc;
	} result_t;

endpackage

[src/crcchk_crc16.sv]
// CRC-16/MODBUS update over one 16-bit word, low byte first.
// Depends on crcchk_pkg.
`timescale 1ns / 1ps

module crcchk_crc16 (
	input  crcchk_pkg::word_t crc_in,
	input  crcchk_pkg::word_t word_in,
	output crcchk_pkg::word_t crc_out
);
	import crcchk_pkg::*;

	function automatic word_t crc_byte(input word_t crc, input logic [7:0] data);
		word_t c;
		c = crc ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	word_t crc_mid;

	assign crc_mid = crc_byte(crc_in, word_in[7:0]);
	assign crc_out = crc_byte(crc_mid, word_in[15:8]);

endmodule

[src/calibration_record_crc_check_top.sv]
// Calibration record check: CRC-16/MODBUS, read-failure and offset tracking.
// A CRC-word item passes the input stage and then the output register before raising m_tvalid.
// Throughput: one item per cycle, set by the combinational 16-bit CRC update, unless a CRC word waits.
// Data words give no result; a stalled result blocks the input only once a CRC word waits.
// Reset (arst_n low, asynchronous) returns the record state to CRC 0xFFFF,
// count zero and flags clear; no clearing pass is needed.
// Depends on crcchk_pkg and crcchk_crc16.
`timescale 1ns / 1ps

module calibration_record_crc_check_top #(
	parameter int unsigned RECORD_WORDS = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] word_value
	input  logic [0:0]  s_tuser,   // [0] read_failed
	input  logic        s_tlast,   // is_crc_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [15:0] computed_crc, [16] record_error,
	                               // [17] uncalibrated, [23:18] zero
);
	import crcchk_pkg::*;

	localparam count_t RW_C = count_t'(RECORD_WORDS);

	// input stage
	logic  valid_s1;
	word_t word_s1;
	logic  failed_s1;
	logic  last_s1;

	// record state
	word_t  crc_q;
	count_t cnt_q;
	logic   fail_q;
	logic   offs_q;

	// output register
	logic    out_valid_q;
	result_t out_q;

	logic    advance;
	logic    in_range;
	word_t   word_eff;
	word_t   crc_next;
	logic    err;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign in_range = (cnt_q < RW_C);
	assign word_eff = failed_s1 ? '0 : word_s1;
	assign err      = fail_q || failed_s1 || (cnt_q != RW_C) || (word_s1 != crc_q);

	crcchk_crc16 u_crc (
		.crc_in  (crc_q),
		.word_in (word_eff),
		.crc_out (crc_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_s1   <= s_tdata;
			failed_s1 <= s_tuser[0];
			last_s1   <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			cnt_q  <= '0;
			fail_q <= 1'b0;
			offs_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				crc_q  <= CRC_INIT;
				cnt_q  <= '0;
				fail_q <= 1'b0;
				offs_q <= 1'b0;
			end else if (!in_range) begin
				// surplus word: drop it, flag the record
				fail_q <= 1'b1;
				if (cnt_q != CNT_MAX) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else begin
				crc_q <= crc_next;
				cnt_q <= cnt_q + 1'b1;
				if (failed_s1) begin
					fail_q <= 1'b1;
				end
				if (cnt_q >= OFFSET_FIRST && cnt_q <= OFFSET_LAST && word_eff != '0) begin
					offs_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_q.computed_crc <= crc_q;
			out_q.record_error <= err;
			out_q.uncalibrated <= err || !offs_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_q};

	// record state is back at reset values after a CRC word is processed
	a_record_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (crc_q == CRC_INIT && cnt_q == '0 && !fail_q && !offs_q))
		else $error("record state not cleared after CRC word");

	// an empty input stage always takes an item
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled while stage empty");

	// a CRC word waiting behind a stalled result blocks the input
	a_block_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input accepted while result path stalled");

	// offset flag can only be set once an offset word has been counted
	a_offset_order: assert property (@(posedge clk) disable iff (!arst_n)
		offs_q |-> (cnt_q > OFFSET_FIRST))
		else $error("offset flag set before offset words");

endmodule

[tb/calibration_record_crc_check_top_tb.sv]
// Testbench for calibration_record_crc_check_top: streams calibration records and checks each
// CRC-word result against a scoreboard that tracks CRC, word count and record flags itself.
// Depends on crcchk_pkg and the top level with its submodules.
`timescale 1ns / 1ps

module calibration_record_crc_check_top_tb;

	import crcchk_pkg::*;

	localparam int RECORD_LEN  = 30;
	localparam int ITEM_TARGET = 600;
	localparam int MIN_RECORDS = 26;
	localparam int HOLD_CYCLES = 300;

	typedef enum int {
		REC_GOOD,
		REC_ZERO_OFFSETS,
		REC_READ_FAIL,
		REC_SHORT,
		REC_LONG,
		REC_BAD_CRC,
		REC_CRC_FAIL,
		REC_NOISE
	} record_kind_t;

	class record_scoreboard;
		int     record_len;
		word_t  crc;
		count_t count;
		bit     failure;
		bit     offset_seen;
		result_t expected_q[$];
		int     errors;
		int     checked;
		int     flagged;
		int     uncal_seen;

		function new(int len);
			record_len = len;
			errors = 0;
			checked = 0;
			flagged = 0;
			uncal_seen = 0;
			restart();
		endfunction

		function void restart();
			crc = CRC_INIT;
			count = '0;
			failure = 1'b0;
			offset_seen = 1'b0;
		endfunction

		// CRC-16/MODBUS over one word, low byte first, one reflected bit at a time
		static function word_t fold_word(word_t c, word_t w);
			logic fb;
			for (int i = 0; i < WORD_W; i++) begin
				fb = c[0] ^ w[i];
				c = c >> 1;
				if (fb)
					c = c ^ CRC_POLY;
			end
			return c;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_item(word_t w, bit f, bit last);
			result_t r;
			bit err;
			if (last) begin
				err = failure || f || (count != record_len) || (w != crc);
				r.computed_crc = crc;
				r.record_error = err;
				r.uncalibrated = err || !offset_seen;
				expected_q.push_back(r);
				restart();
			end else if (count >= record_len) begin
				// surplus word: flag the record, leave the CRC alone
				failure = 1'b1;
				if (count < CNT_MAX)
					count++;
			end else begin
				if (f) begin
					failure = 1'b1;
					w = '0;
				end
				if (count >= OFFSET_FIRST && count <= OFFSET_LAST && w != '0)
					offset_seen = 1'b1;
				crc = fold_word(crc, w);
				count++;
			end
		endfunction

		function void check_result(logic [23:0] d);
			result_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result item: tdata %h", d);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (e.record_error)
				flagged++;
			if (e.uncalibrated)
				uncal_seen++;
			if (d[15:0] !== e.computed_crc) begin
				$error("computed_crc: expected %h, got %h", e.computed_crc, d[15:0]);
				errors++;
			end
			if (d[16] !== e.record_error) begin
				$error("record_error: expected %b, got %b", e.record_error, d[16]);
				errors++;
			end
			if (d[17] !== e.uncalibrated) begin
				$error("uncalibrated: expected %b, got %b", e.uncalibrated, d[17]);
				errors++;
			end
			if (d[23:18] !== 6'd0) begin
				$error("padding: expected %h, got %h", 6'd0, d[23:18]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	record_scoreboard sb;
	bit tx_gaps_on;
	bit rx_gaps_on;
	bit hold_request;
	int items_sent;
	int records_sent;

	calibration_record_crc_check_top #(
		.RECORD_WORDS(RECORD_LEN)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watch both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (s_tvalid && s_tready)
				sb.note_item(s_tdata, s_tuser[0], s_tlast);
		end
	end

	// Receiver: random ready bursts, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input word_t w, input bit f, input bit last);
		if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tuser  <= f;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		items_sent++;
		if (last)
			records_sent++;
	endtask

	task automatic send_record(input record_kind_t kind);
		int    len;
		int    fail_at;
		word_t w;
		word_t run_crc;
		word_t stored;
		bit    f;
		bit    crc_f;
		len = RECORD_LEN;
		fail_at = -1;
		run_crc = CRC_INIT;
		case (kind)
			REC_SHORT: len = $urandom_range(0, RECORD_LEN - 1);
			REC_LONG: begin
				// now and then run the count into saturation
				if ($urandom_range(0, 3) == 0)
					len = $urandom_range(64, 72);
				else
					len = $urandom_range(RECORD_LEN + 1, RECORD_LEN + 6);
			end
			REC_READ_FAIL: fail_at = $urandom_range(0, RECORD_LEN - 1);
			REC_NOISE: len = $urandom_range(0, 40);
			default: ;
		endcase
		for (int i = 0; i < len; i++) begin
			w = word_t'($urandom);
			case ($urandom_range(0, 15))
				0: w = 16'h0000;
				1: w = 16'hFFFF;
				default: ;
			endcase
			if (i >= OFFSET_FIRST && i <= OFFSET_LAST) begin
				if (kind == REC_ZERO_OFFSETS || $urandom_range(0, 3) == 0)
					w = 16'h0000;
			end
			f = (i == fail_at) || (kind == REC_NOISE && $urandom_range(0, 3) == 0);
			if (i < RECORD_LEN)
				run_crc = record_scoreboard::fold_word(run_crc, f ? 16'h0000 : w);
			send_item(w, f, 1'b0);
		end
		stored = run_crc;
		if (kind == REC_BAD_CRC)
			stored = run_crc ^ (16'h0001 << $urandom_range(0, 15));
		else if (kind == REC_NOISE && $urandom_range(0, 1) == 0)
			stored = word_t'($urandom);
		crc_f = (kind == REC_CRC_FAIL) || (kind == REC_NOISE && $urandom_range(0, 3) == 0);
		send_item(stored, crc_f, 1'b1);
	endtask

	function automatic record_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return REC_GOOD;
		if (r < 50) return REC_ZERO_OFFSETS;
		if (r < 60) return REC_READ_FAIL;
		if (r < 70) return REC_SHORT;
		if (r < 78) return REC_LONG;
		if (r < 86) return REC_BAD_CRC;
		if (r < 92) return REC_CRC_FAIL;
		return REC_NOISE;
	endfunction

	// Called at a falling edge; withdraw the offer so nothing is taken while draining
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		sb = new(RECORD_LEN);
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		hold_request = 1'b0;
		items_sent = 0;
		records_sent = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: bare CRC word, failed CRC read, short record with a failed read, bare CRC word, good record
		send_item(16'hFFFF, 1'b0, 1'b1);
		send_item(16'h0000, 1'b1, 1'b1);
		send_item(16'hFFFF, 1'b0, 1'b0);
		send_item(16'h0000, 1'b1, 1'b0);
		send_item(16'hFFFF, 1'b0, 1'b1);
		send_item(16'h0000, 1'b0, 1'b1);
		send_record(REC_GOOD);

		while (items_sent < ITEM_TARGET || records_sent < MIN_RECORDS) begin
			if (records_sent == 8) begin
				// fill the output path: receiver holds off, sender keeps pushing CRC words
				hold_request = 1'b1;
				for (int k = 0; k < 12; k++)
					send_item(word_t'($urandom), 1'($urandom_range(0, 1)), 1'b1);
			end
			if (records_sent == 25) begin
				drain_results();
				send_record(REC_GOOD);
			end
			if (items_sent > ITEM_TARGET - 150 && records_sent >= MIN_RECORDS - 6) begin
				tx_gaps_on = 1'b0;
				rx_gaps_on = 1'b0;
			end
			send_record(pick_kind());
		end
		s_tvalid <= 1'b0;

		drain_results();
		repeat (10) @(negedge clk);
		$display("Run covered %0d items in %0d records; %0d results checked.",
			items_sent, records_sent, sb.checked);
		$display("Of these, %0d carried record_error and %0d uncalibrated.",
			sb.flagged, sb.uncal_seen);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Timeout: %0d results still outstanding", sb.pending());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
